// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant");

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;

	// Fixed beat field widths
	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Per-chain cell control, same for every cell of a chain
	typedef struct packed {
		logic shr;   // take word from the left neighbor (insert at cell 0)
		logic shl;   // take word from the right neighbor (drop cell 0)
		logic app;   // cell whose index equals the count loads the new word
	} cell_ctl_t;

endpackage

// ===== rtl/bdq_if.sv =====
interface bdq_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [bdq_pkg::CMD_W-1:0]            command;
	logic signed [bdq_pkg::VALUE_W-1:0]   push_value;

	modport source (output valid, output command, output push_value, input ready);
	modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface bdq_rsp_if #(
	parameter int OCC_W = $clog2(bdq_pkg::DEPTH_DEF + 1)
);
	logic                                 valid;
	logic                                 ready;
	logic signed [bdq_pkg::VALUE_W-1:0]   pop_value;
	logic [bdq_pkg::STATUS_W-1:0]         status;
	logic [OCC_W-1:0]                     occupancy;

	modport source (output valid, output pop_value, output status, output occupancy,
		input ready);
	modport sink   (input valid, input pop_value, input status, input occupancy,
		output ready);
endinterface

// ===== rtl/bdq_cell.sv =====
module bdq_cell #(
	parameter int WORD_WIDTH = bdq_pkg::WORD_WIDTH_DEF,
	parameter int CNT_W      = $clog2(bdq_pkg::DEPTH_DEF + 1),
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  bdq_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [WORD_WIDTH-1:0] left_word,
	input  logic [WORD_WIDTH-1:0] right_word,
	input  logic [WORD_WIDTH-1:0] new_word,
	output logic [WORD_WIDTH-1:0] word_q
);

	always_ff @(posedge clk) begin
		if (ctl.shr) begin
			word_q <= left_word;
		end else if (ctl.shl) begin
			word_q <= right_word;
		end else if (ctl.app && (count == CNT_W'(IDX))) begin
			word_q <= new_word;
		end
	end

endmodule

// ===== rtl/bdq_chain.sv =====
module bdq_chain #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = bdq_pkg::WORD_WIDTH_DEF,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  bdq_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [WORD_WIDTH-1:0] new_word,
	output logic [WORD_WIDTH-1:0] head_word
);

	logic [WORD_WIDTH-1:0] word [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = new_word;
		end else begin : g_mid_l
			assign left_w = word[i-1];
		end

		// last cell keeps its own word on a left shift; it is past the tail then
		if (i == DEPTH - 1) begin : g_last
			assign right_w = word[i];
		end else begin : g_mid_r
			assign right_w = word[i+1];
		end

		bdq_cell #(
			.WORD_WIDTH (WORD_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count),
			.left_word  (left_w),
			.right_word (right_w),
			.new_word   (new_word),
			.word_q     (word[i])
		);
	end

	assign head_word = word[0];

endmodule

// ===== rtl/bounded_deque.sv =====
// bounded_deque: bounded double-ended queue of signed words.
//
// cmd channel (sink): one beat is one command (push front, push back, pop front,
//   pop back) with the word to push. rsp channel (source): one beat per command
//   with the popped word, a status (ok / full / empty) and the occupancy after it.
// Latency: the response beat shows up the cycle after the command beat.
// Throughput: one command per cycle while responses are taken; each step is a single
//   shift of the cell rows and a count update, so only a waiting response lowers the rate.
// Storage: two rows of DEPTH cells. The front row keeps the front word in cell 0,
//   the back row keeps the back word in cell 0 (reverse order). A push at one end
//   shifts that end's row right and appends to the other row at the cell whose
//   index equals the count; a pop reads cell 0 of its row and shifts it left.
// Rejected commands (push when full, pop when empty) change nothing and return a
//   zero word with the matching status. Zero is an ordinary stored value.
// Reset (arst_n low): count goes to zero and the response register empties.
//   Cell contents are not cleared; the count keeps them out of reach.
// Stall: while a response beat waits on rsp.ready, the next command is held off
//   (cmd.ready low); a beat is taken in the same cycle the waiting one leaves.
`include "assert_macros.svh"

module bounded_deque #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = bdq_pkg::WORD_WIDTH_DEF,
	parameter int OCC_W      = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	bdq_cmd_if.sink            cmd,
	bdq_rsp_if.source          rsp
);

	localparam int VW = bdq_pkg::VALUE_W;

	logic [OCC_W-1:0]                count_q;
	logic [OCC_W-1:0]                count_d;
	logic                            rsp_valid_q;
	logic signed [VW-1:0]            pop_value_q;
	logic [bdq_pkg::STATUS_W-1:0]    status_q;

	logic                            accept;
	logic                            full;
	logic                            empty;
	bdq_pkg::cmd_t                   op;
	bdq_pkg::status_t                status_d;
	logic signed [VW-1:0]            pop_value_d;
	bdq_pkg::cell_ctl_t              front_ctl;
	bdq_pkg::cell_ctl_t              back_ctl;
	logic signed [WORD_WIDTH-1:0]    new_word;
	logic signed [WORD_WIDTH-1:0]    front_head;
	logic signed [WORD_WIDTH-1:0]    back_head;

	// response register frees up in the cycle it is taken
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign full  = (count_q == OCC_W'(DEPTH));
	assign empty = (count_q == '0);
	assign op    = bdq_pkg::cmd_t'(cmd.command);

	// keep low WORD_WIDTH bits (sign-extend if the store is wider than a beat)
	assign new_word = WORD_WIDTH'(cmd.push_value);

	always_comb begin
		front_ctl   = '0;
		back_ctl    = '0;
		status_d    = bdq_pkg::ST_OK;
		pop_value_d = '0;
		count_d     = count_q;
		case (op)
			bdq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = bdq_pkg::ST_FULL;
				end else begin
					front_ctl.shr = 1'b1;
					back_ctl.app  = 1'b1;
					count_d       = count_q + OCC_W'(1);
				end
			end
			bdq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_d = bdq_pkg::ST_FULL;
				end else begin
					back_ctl.shr  = 1'b1;
					front_ctl.app = 1'b1;
					count_d       = count_q + OCC_W'(1);
				end
			end
			bdq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_d = bdq_pkg::ST_EMPTY;
				end else begin
					pop_value_d   = VW'(front_head);
					front_ctl.shl = 1'b1;
					count_d       = count_q - OCC_W'(1);
				end
			end
			bdq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_d = bdq_pkg::ST_EMPTY;
				end else begin
					pop_value_d  = VW'(back_head);
					back_ctl.shl = 1'b1;
					count_d      = count_q - OCC_W'(1);
				end
			end
			default: begin
				status_d = bdq_pkg::ST_OK;
			end
		endcase
		// cells move only on an accepted beat
		if (!accept) begin
			front_ctl = '0;
			back_ctl  = '0;
		end
	end

	bdq_chain #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH),
		.CNT_W      (OCC_W)
	) u_front (
		.clk        (clk),
		.ctl        (front_ctl),
		.count      (count_q),
		.new_word   (new_word),
		.head_word  (front_head)
	);

	bdq_chain #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH),
		.CNT_W      (OCC_W)
	) u_back (
		.clk        (clk),
		.ctl        (back_ctl),
		.count      (count_q),
		.new_word   (new_word),
		.head_word  (back_head)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_value_q <= pop_value_d;
			status_q    <= status_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = count_q;

	// ---- checks ----
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= OCC_W'(DEPTH))

	// with one word stored, both rows must hold it at cell 0
	`ASSERT_IMPL(a_heads_agree, clk, arst_n, count_q == OCC_W'(1), front_head == back_head)

	`ASSERT_NEXT(a_full_reject, clk, arst_n,
		accept && full && (op == bdq_pkg::CMD_PUSH_FRONT || op == bdq_pkg::CMD_PUSH_BACK),
		status_q == bdq_pkg::ST_FULL && count_q == $past(count_q))

	`ASSERT_NEXT(a_ok_moves_count, clk, arst_n,
		accept && status_d == bdq_pkg::ST_OK, count_q != $past(count_q))

endmodule

// ===== test/deque_checker.sv =====
`timescale 1ns / 100ps

module deque_checker (
	input  logic clk,
	input  logic arst_n,
	bdq_cmd_if   cmd,
	bdq_rsp_if   rsp,
	output int   fail_count,
	output int   outstanding
);

	localparam int SLOTS = bdq_pkg::DEPTH_DEF;
	localparam int OCC_W = $clog2(bdq_pkg::DEPTH_DEF + 1);

	typedef struct {
		logic signed [bdq_pkg::VALUE_W-1:0] pop_value;
		bdq_pkg::status_t                   status;
		logic [OCC_W-1:0]                   occupancy;
	} deque_result_t;

	// Shadow deque: circular word store, front slot and fill level
	logic signed [bdq_pkg::VALUE_W-1:0] words [SLOTS];
	int                                 front_slot;
	int                                 fill;
	deque_result_t                      pending_results [$];

	function automatic deque_result_t deque_apply(bdq_pkg::cmd_t op,
		logic signed [bdq_pkg::VALUE_W-1:0] word);
		deque_result_t r;
		r.pop_value = '0;
		r.status    = bdq_pkg::ST_OK;
		case (op)
			bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
				if (fill == SLOTS) begin
					r.status = bdq_pkg::ST_FULL;
				end else if (op == bdq_pkg::CMD_PUSH_FRONT) begin
					front_slot = (front_slot + SLOTS - 1) % SLOTS;
					words[front_slot] = word;
					fill++;
				end else begin
					words[(front_slot + fill) % SLOTS] = word;
					fill++;
				end
			end
			default: begin
				if (fill == 0) begin
					r.status = bdq_pkg::ST_EMPTY;
				end else if (op == bdq_pkg::CMD_POP_FRONT) begin
					r.pop_value = words[front_slot];
					front_slot  = (front_slot + 1) % SLOTS;
					fill--;
				end else begin
					r.pop_value = words[(front_slot + fill - 1) % SLOTS];
					fill--;
				end
			end
		endcase
		r.occupancy = OCC_W'(fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			pending_results.delete();
			front_slot  = 0;
			fill        = 0;
			fail_count  = 0;
			outstanding = 0;
		end else begin
			// response beat belongs to an earlier command, so check before predicting
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected beat: value=%0d status=%0d occupancy=%0d",
						$time, rsp.pop_value, rsp.status, rsp.occupancy);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.pop_value !== want.pop_value || rsp.status !== want.status ||
						rsp.occupancy !== want.occupancy) begin
						$display("%0t: mismatch: expected value=%0d status=%0d occupancy=%0d",
							$time, want.pop_value, want.status, want.occupancy,
							", got value=%0d status=%0d occupancy=%0d",
							rsp.pop_value, rsp.status, rsp.occupancy);
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				pending_results.push_back(deque_apply(bdq_pkg::cmd_t'(cmd.command),
					cmd.push_value));
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== test/tb_bounded_deque.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for bounded_deque. The checker beside the DUT tracks
// every accepted command beat and compares every response beat.
module tb_bounded_deque;

	localparam int SLOTS      = bdq_pkg::DEPTH_DEF;
	localparam int PHASE_CMDS = 440;   // four phases, 1760 random commands total

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;

	// idling knobs, percent of cycles
	int   gap_pct;
	int   stall_pct;
	// one-shot request for a long receiver hold-off; the receiver counts it out
	bit   long_hold_req;
	int   hold_left;

	bdq_cmd_if cmd_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	deque_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run (both sides idling, long hold).
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: one decision per falling edge. The long hold-off overrides the
	// random stall so the DUT fills its response register and backs up cmd.
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left     = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one command beat; gaps land before it at the sender's idle rate.
	// Returns at the rising edge where the beat is taken.
	task automatic send_beat(input bdq_pkg::cmd_t op,
		input logic signed [bdq_pkg::VALUE_W-1:0] word);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= op;
		cmd_ch.push_value <= word;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// Mostly random words, with the corner words mixed in now and then.
	function automatic logic signed [bdq_pkg::VALUE_W-1:0] pick_word();
		case ($urandom_range(15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			default: return $signed($urandom);
		endcase
	endfunction

	// Random traffic in bursts: each burst leans toward pushes, pops or neither,
	// so occupancy sweeps between empty and full and both rejects show up often.
	task automatic run_bursts(input int count, input bit with_hold);
		int            sent;
		int            burst_left;
		int            push_pct;
		bdq_pkg::cmd_t op;
		sent       = 0;
		burst_left = 0;
		push_pct   = 50;
		while (sent < count) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 4);
				case ($urandom_range(2))
					0:       push_pct = 15;
					1:       push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			if ($urandom_range(99) < push_pct)
				op = $urandom_range(1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT;
			else
				op = $urandom_range(1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT;
			// long receiver hold-off while we keep offering beats
			if (with_hold && sent == 100)
				long_hold_req = 1'b1;
			send_beat(op, pick_word());
			burst_left--;
			sent++;
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.command    = bdq_pkg::CMD_PUSH_FRONT;
		cmd_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		gap_pct           = 0;
		stall_pct         = 0;
		long_hold_req     = 1'b0;
		hold_left         = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: pops on empty, extreme words at both ends, zero as a stored
		// word, then fill to full, try both pushes against the full deque and pop both ends.
		send_beat(bdq_pkg::CMD_POP_FRONT, 32'sh1234_5678);
		send_beat(bdq_pkg::CMD_POP_BACK, -32'sd1);
		send_beat(bdq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000);
		send_beat(bdq_pkg::CMD_PUSH_BACK, 32'sh7FFF_FFFF);
		send_beat(bdq_pkg::CMD_POP_BACK, '0);
		send_beat(bdq_pkg::CMD_POP_FRONT, '0);
		send_beat(bdq_pkg::CMD_PUSH_FRONT, '0);
		send_beat(bdq_pkg::CMD_PUSH_BACK, -32'sd1);
		for (int i = 2; i < SLOTS; i++)
			send_beat(i[0] ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT, pick_word());
		send_beat(bdq_pkg::CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_beat(bdq_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
		send_beat(bdq_pkg::CMD_POP_FRONT, '0);
		send_beat(bdq_pkg::CMD_POP_BACK, '0);

		// Random phases: no idling but one long receiver hold-off, sender gaps, receiver stalls, both.
		gap_pct = 0;  stall_pct = 0;
		run_bursts(PHASE_CMDS, 1'b1);
		gap_pct = 55; stall_pct = 0;
		run_bursts(PHASE_CMDS, 1'b0);
		gap_pct = 0;  stall_pct = 55;
		run_bursts(PHASE_CMDS, 1'b0);
		gap_pct = 33; stall_pct = 33;
		run_bursts(PHASE_CMDS, 1'b0);

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		// drain: every expected response must arrive; the timeout catches a hang
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_cell.sv
rtl/bdq_chain.sv
rtl/bounded_deque.sv
test/deque_checker.sv
test/tb_bounded_deque.sv
